### sv/assert_macros.svh
// Assertion macros used by the running statistics top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante holds at an edge -> cons holds at the same edge
`define RSW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// ante holds at an edge -> cons holds at the next edge
`define RSW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RSW_ASSERT_IMP(label, clk, rst, ante, cons)
`define RSW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/rsw_pkg.sv
// Types and constants shared by the running statistics block.
`timescale 1ns / 1ps
package rsw_pkg;

   // multiplier operand selects
   localparam logic [2:0] MS_SQ  = 3'd0;
   localparam logic [2:0] MS_A0  = 3'd1;
   localparam logic [2:0] MS_A1  = 3'd2;
   localparam logic [2:0] MS_B00 = 3'd3;
   localparam logic [2:0] MS_B01 = 3'd4;
   localparam logic [2:0] MS_B10 = 3'd5;
   localparam logic [2:0] MS_B11 = 3'd6;
   localparam logic [2:0] MS_D   = 3'd7;

   // divider operations
   localparam logic [1:0] OP_VAR  = 2'd0;
   localparam logic [1:0] OP_MEAN = 2'd1;
   localparam logic [1:0] OP_WM   = 2'd2;

   localparam logic [63:0] VAR_CAP  = 64'h4000_0000_0000_0000;
   localparam logic [39:0] MEAN_CAP = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic       capture;
      logic       load;
      logic       update;
      logic       mul_go;
      logic [2:0] mul_sel;
      logic       diff;
      logic       div_start;
      logic [1:0] div_op;
      logic       sqrt_start;
      logic       out_load;
   } rsw_cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
   } rsw_stat_type;

endpackage

### sv/rsw_ctrl.sv
// Sequencer for the running statistics block.
`timescale 1ns / 1ps
module rsw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsw_pkg::rsw_stat_type stat,
   output rsw_pkg::rsw_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LOAD     = 4'd1;
   localparam logic [3:0] S_UPD      = 4'd2;
   localparam logic [3:0] S_MUL      = 4'd3;
   localparam logic [3:0] S_DIFF     = 4'd4;
   localparam logic [3:0] S_DIV_GO   = 4'd5;
   localparam logic [3:0] S_DIV_WAIT = 4'd6;
   localparam logic [3:0] S_SQ_GO    = 4'd7;
   localparam logic [3:0] S_SQ_WAIT  = 4'd8;
   localparam logic [3:0] S_FIN      = 4'd9;

   localparam logic [2:0] MUL_STEPS = 3'd7;

   logic [3:0] state_ff, state_in;
   logic [2:0] mcnt_ff, mcnt_in;
   logic [1:0] op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      mcnt_in  = mcnt_ff;
      op_in    = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.update = 1'b1;
            mcnt_in    = '0;
            state_in   = S_MUL;
         end
         S_MUL: begin
            if (mcnt_ff != MUL_STEPS) begin
               cmd.mul_go = 1'b1;
               mcnt_in    = mcnt_ff + 3'd1;
               case (mcnt_ff)
                  3'd0:    cmd.mul_sel = rsw_pkg::MS_A0;
                  3'd1:    cmd.mul_sel = rsw_pkg::MS_A1;
                  3'd2:    cmd.mul_sel = rsw_pkg::MS_B00;
                  3'd3:    cmd.mul_sel = rsw_pkg::MS_B01;
                  3'd4:    cmd.mul_sel = rsw_pkg::MS_B10;
                  3'd5:    cmd.mul_sel = rsw_pkg::MS_B11;
                  default: cmd.mul_sel = rsw_pkg::MS_D;
               endcase
            end else begin
               state_in = S_DIFF;   // last product lands this cycle
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            op_in    = rsw_pkg::OP_VAR;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = op_ff;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               case (op_ff)
                  rsw_pkg::OP_VAR: begin
                     op_in    = rsw_pkg::OP_MEAN;
                     state_in = S_DIV_GO;
                  end
                  rsw_pkg::OP_MEAN: begin
                     op_in    = rsw_pkg::OP_WM;
                     state_in = S_DIV_GO;
                  end
                  default: state_in = S_SQ_GO;
               endcase
            end
         end
         S_SQ_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (stat.sqrt_done) state_in = S_FIN;
         end
         S_FIN: begin
            // wait for the output word to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mcnt_ff      <= '0;
         op_ff        <= rsw_pkg::OP_VAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mcnt_ff      <= mcnt_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/rsw_dp.sv
// Datapath: statistics registers, window ring, multiplier, divider and root unit.
`timescale 1ns / 1ps
module rsw_dp #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsw_pkg::rsw_cmd_type  cmd,
   output rsw_pkg::rsw_stat_type stat,
   input  logic                  req_mode,
   input  logic [31:0]           req_value,
   input  logic                  csr_write_enable,
   input  logic [8:0]            csr_write_data,
   output logic [31:0]           rsp_entry_count,
   output logic [31:0]           rsp_minimum,
   output logic [31:0]           rsp_maximum,
   output logic [63:0]           rsp_total,
   output logic [39:0]           rsp_mean,
   output logic [62:0]           rsp_variance,
   output logic [31:0]           rsp_std_deviation,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0] rsp_window_fill,
   output logic [39:0]           rsp_window_mean,
   output logic                  rsp_overflow
);

   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int WSUM_W = $clog2(WINDOW_DEPTH) + 32;
   localparam int WM_BITS = WSUM_W + 8;

   // sample and statistics
   logic              mode_ff;
   logic [31:0]       val_ff;
   logic [31:0]       count_ff, min_ff, max_ff;
   logic [63:0]       sum_ff, ssq_ff;
   logic              ovf_ff;
   logic [8:0]        wlen_ff;
   logic [AW-1:0]     wpos_ff;
   logic [FILL_W-1:0] fill_ff, len;
   logic [WSUM_W-1:0] wsum_ff;
   logic [31:0]       mem [WINDOW_DEPTH];
   logic [31:0]       rd_ff;

   // multiplier
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  prod_ff;
   logic [2:0]   sel_ff;
   logic         go_ff;
   logic [95:0]  acc_a_ff;
   logic [127:0] acc_b_ff;
   logic [63:0]  den_ff;
   logic [127:0] diff_ff;
   logic         var_zero_ff;

   // divider
   logic         dbusy_ff;
   logic [7:0]   dcnt_ff;
   logic [1:0]   dop_ff;
   logic [127:0] num_ff;
   logic [64:0]  rem_ff, rem_sh;
   logic [63:0]  q_ff, q_next, dden;
   logic         qovf_ff, qbit;
   logic [62:0]  var_ff;
   logic [39:0]  mean_ff, wm_ff;

   // root
   logic         sbusy_ff;
   logic [5:0]   scnt_ff;
   logic [63:0]  sv_ff, res_ff, bit_ff, strial;

   logic [64:0]       sum_add, ssq_add;
   logic [WSUM_W-1:0] v_ext;

   always_comb begin
      if (32'(wlen_ff) < 32'(WINDOW_DEPTH)) len = FILL_W'(wlen_ff);
      else len = FILL_W'(WINDOW_DEPTH);
   end

   assign sum_add = {1'b0, sum_ff} + {33'b0, val_ff};
   assign ssq_add = {1'b0, ssq_ff} + {1'b0, prod_ff};
   assign v_ext   = WSUM_W'(val_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         val_ff  <= req_value;
      end
      if (cmd.load) rd_ff <= mem[wpos_ff];
      if (cmd.update && !mode_ff && len != '0) mem[wpos_ff] <= val_ff;
   end

   // statistics and window bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ssq_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         ovf_ff   <= 1'b0;
         wlen_ff  <= 9'd256;
         wpos_ff  <= '0;
         fill_ff  <= '0;
         wsum_ff  <= '0;
      end else if (csr_write_enable) begin
         wlen_ff <= csr_write_data;
         wpos_ff <= '0;
         fill_ff <= '0;
         wsum_ff <= '0;
      end else if (cmd.update) begin
         if (mode_ff) begin
            count_ff <= '0;
            sum_ff   <= '0;
            ssq_ff   <= '0;
            min_ff   <= '0;
            max_ff   <= '0;
            ovf_ff   <= 1'b0;
            wpos_ff  <= '0;
            fill_ff  <= '0;
            wsum_ff  <= '0;
         end else begin
            if (count_ff == '0) begin
               min_ff <= val_ff;
               max_ff <= val_ff;
            end else begin
               if (val_ff < min_ff) min_ff <= val_ff;
               if (val_ff > max_ff) max_ff <= val_ff;
            end
            if (count_ff == '1) ovf_ff <= 1'b1;
            else count_ff <= count_ff + 32'd1;
            if (sum_add[64]) begin
               sum_ff <= '1;
               ovf_ff <= 1'b1;
            end else begin
               sum_ff <= sum_add[63:0];
            end
            if (ssq_add[64]) begin
               ssq_ff <= '1;
               ovf_ff <= 1'b1;
            end else begin
               ssq_ff <= ssq_add[63:0];
            end
            if (len != '0) begin
               if (fill_ff >= len) begin
                  wsum_ff <= wsum_ff - WSUM_W'(rd_ff) + v_ext;
               end else begin
                  fill_ff <= fill_ff + FILL_W'(1);
                  wsum_ff <= wsum_ff + v_ext;
               end
               if (32'(wpos_ff) + 32'd1 >= 32'(len)) wpos_ff <= '0;
               else wpos_ff <= wpos_ff + AW'(1);
            end
         end
      end
   end

   // shared 32x32 multiplier, one registered product per cycle
   always_comb begin
      case (cmd.mul_sel)
         rsw_pkg::MS_SQ:  begin mul_a = val_ff;        mul_b = val_ff;        end
         rsw_pkg::MS_A0:  begin mul_a = count_ff;      mul_b = ssq_ff[31:0];  end
         rsw_pkg::MS_A1:  begin mul_a = count_ff;      mul_b = ssq_ff[63:32]; end
         rsw_pkg::MS_B00: begin mul_a = sum_ff[31:0];  mul_b = sum_ff[31:0];  end
         rsw_pkg::MS_B01: begin mul_a = sum_ff[31:0];  mul_b = sum_ff[63:32]; end
         rsw_pkg::MS_B10: begin mul_a = sum_ff[63:32]; mul_b = sum_ff[31:0];  end
         rsw_pkg::MS_B11: begin mul_a = sum_ff[63:32]; mul_b = sum_ff[63:32]; end
         rsw_pkg::MS_D:   begin mul_a = count_ff;      mul_b = count_ff;      end
         default:         begin mul_a = val_ff;        mul_b = val_ff;        end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      sel_ff  <= cmd.mul_sel;
      if (reset) go_ff <= 1'b0;
      else go_ff <= cmd.mul_go;
      if (cmd.update) begin
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else if (go_ff) begin
         case (sel_ff)
            rsw_pkg::MS_A0:  acc_a_ff <= acc_a_ff + 96'(prod_ff);
            rsw_pkg::MS_A1:  acc_a_ff <= acc_a_ff + {prod_ff, 32'b0};
            rsw_pkg::MS_B00: acc_b_ff <= acc_b_ff + 128'(prod_ff);
            rsw_pkg::MS_B01, rsw_pkg::MS_B10:
                             acc_b_ff <= acc_b_ff + 128'({prod_ff, 32'b0});
            rsw_pkg::MS_B11: acc_b_ff <= acc_b_ff + {prod_ff, 64'b0};
            rsw_pkg::MS_D:   den_ff   <= prod_ff;
            default:         ;
         endcase
      end
      if (cmd.diff) begin
         diff_ff     <= {32'b0, acc_a_ff} - acc_b_ff;
         var_zero_ff <= ({32'b0, acc_a_ff} < acc_b_ff) || (count_ff == '0);
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      case (dop_ff)
         rsw_pkg::OP_VAR:  dden = den_ff;
         rsw_pkg::OP_MEAN: dden = 64'(count_ff);
         default:          dden = 64'(fill_ff);
      endcase
      rem_sh = {rem_ff[63:0], num_ff[127]};
      qbit   = (rem_sh >= {1'b0, dden});
      q_next = {q_ff[62:0], qbit};
   end

   assign stat.div_done  = dbusy_ff && (dcnt_ff == 8'd1);
   assign stat.sqrt_done = sbusy_ff && (scnt_ff == 6'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
      end else if (stat.div_done) begin
         dbusy_ff <= 1'b0;
      end
      if (cmd.div_start) begin
         dop_ff  <= cmd.div_op;
         rem_ff  <= '0;
         q_ff    <= '0;
         qovf_ff <= 1'b0;
         case (cmd.div_op)
            rsw_pkg::OP_VAR: begin
               num_ff  <= diff_ff;
               dcnt_ff <= 8'd128;
            end
            rsw_pkg::OP_MEAN: begin
               num_ff  <= {sum_ff, 8'b0, 56'b0};
               dcnt_ff <= 8'd72;
            end
            default: begin
               num_ff  <= {wsum_ff, 8'b0, {(128 - WM_BITS){1'b0}}};
               dcnt_ff <= 8'(WM_BITS);
            end
         endcase
      end else if (dbusy_ff) begin
         num_ff  <= {num_ff[126:0], 1'b0};
         rem_ff  <= qbit ? (rem_sh - {1'b0, dden}) : rem_sh;
         q_ff    <= q_next;
         qovf_ff <= qovf_ff | q_ff[63];
         dcnt_ff <= dcnt_ff - 8'd1;
         if (dcnt_ff == 8'd1) begin
            case (dop_ff)
               rsw_pkg::OP_VAR: begin
                  if (var_zero_ff) var_ff <= '0;
                  else if (qovf_ff || q_ff[63] || q_next > rsw_pkg::VAR_CAP)
                     var_ff <= rsw_pkg::VAR_CAP[62:0];
                  else var_ff <= q_next[62:0];
               end
               rsw_pkg::OP_MEAN: begin
                  if (count_ff == '0) mean_ff <= '0;
                  else if (qovf_ff || q_ff[63] || q_next > 64'(rsw_pkg::MEAN_CAP))
                     mean_ff <= rsw_pkg::MEAN_CAP;
                  else mean_ff <= q_next[39:0];
               end
               default: begin
                  if (fill_ff == '0) wm_ff <= '0;
                  else if (qovf_ff || q_ff[63] || q_next > 64'(rsw_pkg::MEAN_CAP))
                     wm_ff <= rsw_pkg::MEAN_CAP;
                  else wm_ff <= q_next[39:0];
               end
            endcase
         end
      end
   end

   // digit-by-digit square root, two radicand bits per cycle
   assign strial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sbusy_ff <= 1'b1;
      end else if (stat.sqrt_done) begin
         sbusy_ff <= 1'b0;
      end
      if (cmd.sqrt_start) begin
         sv_ff   <= 64'(var_ff);
         res_ff  <= '0;
         bit_ff  <= 64'h4000_0000_0000_0000;
         scnt_ff <= 6'd32;
      end else if (sbusy_ff) begin
         if (sv_ff >= strial) begin
            sv_ff  <= sv_ff - strial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff  <= bit_ff >> 2;
         scnt_ff <= scnt_ff - 6'd1;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_entry_count   <= count_ff;
         rsp_minimum       <= min_ff;
         rsp_maximum       <= max_ff;
         rsp_total         <= sum_ff;
         rsp_mean          <= mean_ff;
         rsp_variance      <= var_ff;
         rsp_std_deviation <= res_ff[31:0];
         rsp_window_fill   <= fill_ff;
         rsp_window_mean   <= wm_ff;
         rsp_overflow      <= ovf_ff;
      end
   end

endmodule

### sv/running_stats_with_window.sv
// Running statistics top level: one word in, one statistics word out.
// A new word is accepted only once the previous result is in the output word; the
// 128-step variance division in the shared divider dominates the work on each word.
// A result may wait while the next word runs.
// Reset (synchronous, active high) clears all statistics, window length = 256.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module running_stats_with_window #(
   parameter int WINDOW_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_entry_count,
   output logic [31:0] rsp_minimum,
   output logic [31:0] rsp_maximum,
   output logic [63:0] rsp_total,
   output logic [39:0] rsp_mean,
   output logic [62:0] rsp_variance,
   output logic [31:0] rsp_std_deviation,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0] rsp_window_fill,
   output logic [39:0] rsp_window_mean,
   output logic        rsp_overflow,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data
);

   rsw_pkg::rsw_cmd_type  cmd;
   rsw_pkg::rsw_stat_type stat;

   rsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsw_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_minimum       (rsp_minimum),
      .rsp_maximum       (rsp_maximum),
      .rsp_total         (rsp_total),
      .rsp_mean          (rsp_mean),
      .rsp_variance      (rsp_variance),
      .rsp_std_deviation (rsp_std_deviation),
      .rsp_window_fill   (rsp_window_fill),
      .rsp_window_mean   (rsp_window_mean),
      .rsp_overflow      (rsp_overflow)
   );

   `RSW_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `RSW_ASSERT_IMP(a_fill_le_count, clock, reset, rsp_valid, 32'(rsp_window_fill) <= rsp_entry_count)
   `RSW_ASSERT_IMP(a_min_le_max, clock, reset, rsp_valid && rsp_entry_count != 32'd0, rsp_minimum <= rsp_maximum)
   `RSW_ASSERT_IMP(a_root_bound, clock, reset, rsp_valid, 64'(rsp_std_deviation) * 64'(rsp_std_deviation) <= 64'(rsp_variance))

endmodule

### test/running_stats_with_window_test.sv
// Self-checking testbench for running_stats_with_window: directed table plus random words.
`timescale 1ns / 1ps
module running_stats_with_window_test;

   localparam int DEPTH      = 256;
   localparam int DRAIN_WAIT = 400;
   localparam int IDLE_LIMIT = 20000;
   localparam bit MODE_ADD   = 1'b0;
   localparam bit MODE_CLEAR = 1'b1;

   typedef struct {
      logic [31:0] entry_count;
      logic [31:0] minimum;
      logic [31:0] maximum;
      logic [63:0] total;
      logic [39:0] mean;
      logic [62:0] variance;
      logic [31:0] std_deviation;
      logic [8:0]  window_fill;
      logic [39:0] window_mean;
      logic        overflow;
   } stats_type;

   typedef struct {
      bit          mode;
      logic [31:0] value;
      bit          typed;
      logic [31:0] entry_count;
      logic [31:0] minimum;
      logic [31:0] maximum;
      logic [63:0] total;
      bit          overflow;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_entry_count, rsp_minimum, rsp_maximum, rsp_std_deviation;
   logic [63:0] rsp_total;
   logic [39:0] rsp_mean, rsp_window_mean;
   logic [62:0] rsp_variance;
   logic [8:0]  rsp_window_fill;
   logic        rsp_overflow;
   logic        csr_write_enable = 1'b0;
   logic [8:0]  csr_write_data = '0;

   running_stats_with_window #(.WINDOW_DEPTH(DEPTH)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [8:0]  win_len;
   logic [31:0] n_samples, lo_seen, hi_seen;
   logic [63:0] sum_acc, sq_acc, win_sum;
   logic [31:0] win_ring [DEPTH];
   int          win_pos, win_fill;
   bit          sat_flag;

   stats_type pending_stats [$];
   int     errors = 0;
   int     words_sent = 0, clears_sent = 0, words_seen = 0, ovf_seen = 0;
   int     idle_cycles = 0;
   bit     calm = 1'b0;
   int     seg_shift = 0;

   dir_row_type dir_table [0:15] = '{
      '{MODE_CLEAR, 32'd99,        1, 32'd0, 32'd0, 32'd0, 64'd0, 0},
      '{MODE_ADD,   32'd0,         1, 32'd1, 32'd0, 32'd0, 64'd0, 0},
      '{MODE_ADD,   32'd7,         1, 32'd2, 32'd0, 32'd7, 64'd7, 0},
      '{MODE_ADD,   32'hFFFF_FFFF, 1, 32'd3, 32'd0, 32'hFFFF_FFFF, 64'h1_0000_0006, 0},
      '{MODE_ADD,   32'hFFFF_FFFF, 1, 32'd4, 32'd0, 32'hFFFF_FFFF, 64'h2_0000_0005, 1},
      '{MODE_ADD,   32'd1,         0, '0, '0, '0, '0, 0},
      '{MODE_CLEAR, 32'hFFFF_FFFF, 1, 32'd0, 32'd0, 32'd0, 64'd0, 0},
      '{MODE_ADD,   32'd12345,     1, 32'd1, 32'd12345, 32'd12345, 64'd12345, 0},
      '{MODE_ADD,   32'd3,         0, '0, '0, '0, '0, 0},
      '{MODE_ADD,   32'd9,         0, '0, '0, '0, '0, 0},
      '{MODE_ADD,   32'h8000_0000, 0, '0, '0, '0, '0, 0},
      '{MODE_ADD,   32'h7FFF_FFFF, 0, '0, '0, '0, '0, 0},
      '{MODE_CLEAR, 32'd0,         1, 32'd0, 32'd0, 32'd0, 64'd0, 0},
      '{MODE_ADD,   32'hFFFF_FFFF, 1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        64'hFFFF_FFFF, 0},
      '{MODE_ADD,   32'd0,         0, '0, '0, '0, '0, 0},
      '{MODE_ADD,   32'd5,         0, '0, '0, '0, '0, 0}
   };

   function automatic logic [39:0] q8_avg(logic [63:0] s, logic [63:0] n);
      logic [127:0] q;
      if (n == 0) return '0;
      q = (128'(s) << 8) / 128'(n);
      return (q > 128'(rsw_pkg::MEAN_CAP)) ? rsw_pkg::MEAN_CAP : q[39:0];
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic void empty_window();
      win_pos = 0;
      win_fill = 0;
      win_sum = '0;
   endfunction

   function automatic void wipe_stats();
      n_samples = '0;
      sum_acc = '0;
      sq_acc = '0;
      lo_seen = '0;
      hi_seen = '0;
      sat_flag = 0;
      empty_window();
   endfunction

   function automatic stats_type next_stats(bit mode, logic [31:0] v);
      stats_type e;
      logic [64:0]  wide_sum;
      logic [127:0] num_a, num_b, var_q;
      int len, pos;
      len = (win_len < DEPTH) ? win_len : DEPTH;
      if (mode == MODE_CLEAR) begin
         wipe_stats();
      end else begin
         if (n_samples == 0) begin
            lo_seen = v;
            hi_seen = v;
         end else begin
            if (v < lo_seen) lo_seen = v;
            if (v > hi_seen) hi_seen = v;
         end
         if (n_samples == 32'hFFFF_FFFF) sat_flag = 1;
         else n_samples = n_samples + 1;
         wide_sum = 65'(sum_acc) + 65'(v);
         if (wide_sum[64]) begin
            sum_acc = '1;
            sat_flag = 1;
         end else sum_acc = wide_sum[63:0];
         wide_sum = 65'(sq_acc) + 65'(64'(v) * 64'(v));
         if (wide_sum[64]) begin
            sq_acc = '1;
            sat_flag = 1;
         end else sq_acc = wide_sum[63:0];
         if (len != 0) begin
            pos = (win_pos < len) ? win_pos : 0;
            if (win_fill >= len) win_sum = win_sum - win_ring[pos];
            else win_fill++;
            win_ring[pos] = v;
            win_sum = win_sum + v;
            pos++;
            win_pos = (pos >= len) ? 0 : pos;
         end
      end
      e.variance = '0;
      if (n_samples != 0) begin
         num_a = 128'(n_samples) * 128'(sq_acc);
         num_b = 128'(sum_acc) * 128'(sum_acc);
         if (num_a >= num_b) begin
            var_q = (num_a - num_b) / (128'(n_samples) * 128'(n_samples));
            e.variance = (var_q > 128'(rsw_pkg::VAR_CAP)) ? rsw_pkg::VAR_CAP[62:0]
                                                         : var_q[62:0];
         end
      end
      e.entry_count   = n_samples;
      e.minimum       = lo_seen;
      e.maximum       = hi_seen;
      e.total         = sum_acc;
      e.mean          = q8_avg(sum_acc, 64'(n_samples));
      e.std_deviation = 32'(int_root(64'(e.variance)));
      e.window_fill   = win_fill[8:0];
      e.window_mean   = q8_avg(win_sum, 64'(win_fill));
      e.overflow      = sat_flag;
      return e;
   endfunction

   task automatic report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10)
         $display("ERROR word %0d %s: expected %h got %h", words_seen, field, want, got);
   endtask

   // response side
   always @(posedge clock) begin
      stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (pending_stats.size() == 0) begin
            report("unexpected word", '0, 64'(rsp_entry_count));
         end else begin
            want = pending_stats.pop_front();
            if (rsp_entry_count !== want.entry_count)
               report("entry_count", 64'(want.entry_count), 64'(rsp_entry_count));
            if (rsp_minimum !== want.minimum)
               report("minimum", 64'(want.minimum), 64'(rsp_minimum));
            if (rsp_maximum !== want.maximum)
               report("maximum", 64'(want.maximum), 64'(rsp_maximum));
            if (rsp_total !== want.total) report("total", want.total, rsp_total);
            if (rsp_mean !== want.mean) report("mean", 64'(want.mean), 64'(rsp_mean));
            if (rsp_variance !== want.variance)
               report("variance", 64'(want.variance), 64'(rsp_variance));
            if (rsp_std_deviation !== want.std_deviation)
               report("std_deviation", 64'(want.std_deviation), 64'(rsp_std_deviation));
            if (rsp_window_fill !== want.window_fill)
               report("window_fill", 64'(want.window_fill), 64'(rsp_window_fill));
            if (rsp_window_mean !== want.window_mean)
               report("window_mean", 64'(want.window_mean), 64'(rsp_window_mean));
            if (rsp_overflow !== want.overflow)
               report("overflow", 64'(want.overflow), 64'(rsp_overflow));
            if (want.overflow) ovf_seen++;
         end
      end
   end

   // receiver back-pressure: runs of stall and flow, occasionally long
   int stall_left = 0;
   always @(negedge clock) begin
      int r;
      if (stall_left > 0) begin
         stall_left--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
         stall_left = 50;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(1, 8);
         end else if (r < 95) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 4);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(50, 500);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(30, 600);
   endfunction

   // returns once the word is accepted; expectation computed at that edge and returned to the caller
   task automatic send_word(bit mode, logic [31:0] v, output stats_type e);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      e = next_stats(mode, v);
      words_sent++;
      if (mode == MODE_CLEAR) clears_sent++;
   endtask

   task automatic drain();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   task automatic set_window(logic [8:0] len);
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(negedge clock) csr_write_enable <= 1'b0;
      win_len = len;
      empty_window();
   endtask

   task automatic random_word();
      stats_type e;
      logic [31:0] v;
      int r;
      bit mode;
      r = $urandom_range(0, 99);
      mode = (r < 3) ? MODE_CLEAR : MODE_ADD;
      if (mode == MODE_CLEAR) seg_shift = $urandom_range(0, 31);
      r = $urandom_range(0, 99);
      if (r < 5) v = '0;
      else if (r < 10) v = '1;
      else if (r < 15) v = 32'hFFFF_FFFF - $urandom_range(0, 255);
      else v = $urandom >> seg_shift;
      send_word(mode, v, e);
      pending_stats.push_back(e);
   endtask

   localparam int NPHASE = 9;
   int phase_len   [NPHASE] = '{1, 0, 3, 511, 2, 37, 256, 0, 255};
   int phase_words [NPHASE] = '{80, 60, 80, 300, 60, 110, 280, 0, 90};

   initial begin
      stats_type e;
      win_len = 9'd256;
      wipe_stats();
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (dir_table[i]) begin
         send_word(dir_table[i].mode, dir_table[i].value, e);
         if (dir_table[i].typed) begin
            e.entry_count = dir_table[i].entry_count;
            e.minimum     = dir_table[i].minimum;
            e.maximum     = dir_table[i].maximum;
            e.total       = dir_table[i].total;
            e.overflow    = dir_table[i].overflow;
         end
         pending_stats.push_back(e);
      end

      phase_len[7] = $urandom_range(0, 511);
      phase_words[7] = 100;
      for (int p = 0; p < NPHASE; p++) begin
         set_window(phase_len[p][8:0]);
         calm = (p % 3 == 1);
         for (int k = 0; k < phase_words[p]; k++) begin
            // hold the sender once until the pipeline is empty
            if (p == 4 && k == 30) drain();
            random_word();
         end
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d words (%0d clears) over %0d window lengths, checked %0d results",
               words_sent, clears_sent, NPHASE, words_seen);
      $display("Results with sticky overflow set: %0d", ovf_seen);
      if (errors == 0 && pending_stats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, pending_stats.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
